// ===== rtl/core/hkpt_pkg.sv =====
// Shared types, constants and reset values for the hue keyed pixel tint block.
// No dependencies; every other file in rtl/core but hkpt_checker refers to this package.
package hkpt_pkg;

  // Configuration port geometry and register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] REG_TINT_RED  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TINT_GRN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TINT_BLU  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BLEND_WT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUE_LOWER = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HUE_UPPER = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_TINT      = 8'd255;
  localparam logic [8:0] RST_BLEND_WT  = 9'd205;
  localparam logic [7:0] RST_HUE_LOWER = 8'd12;
  localparam logic [7:0] RST_HUE_UPPER = 8'd24;

  // Depth of the queue between classifier and tint datapath
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0] tint_red;
    logic [7:0] tint_green;
    logic [7:0] tint_blue;
    logic [8:0] blend_weight;
    logic [7:0] hue_lower_bound;
    logic [7:0] hue_upper_bound;
  } cfg_t;

  // Blue sits in the low byte, matching the stream packing
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic matched;
    pix_t pix;
  } item_t;

endpackage

// ===== rtl/core/hkpt_front.sv =====
// Front end: hue computation (pipelined restoring divider) and hue window test.
// Depends on hkpt_pkg.
module hkpt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkpt_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hkpt_pkg::pix_t      in_pix_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hkpt_pkg::item_t     out_item_o
);

  localparam int unsigned QuoW      = 8;          // hue quotient bits, one per stage
  localparam int unsigned RemW      = 17;         // 60*n + d stays below 2^17
  localparam int unsigned DenW      = 9;          // 2*d
  localparam int unsigned NumStages = QuoW + 2;   // capture, prep, divider steps
  localparam logic [QuoW-1:0] HueWrap = 8'd180;

  typedef struct packed {
    hkpt_pkg::pix_t  pix;
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } stage_t;

  stage_t               st_q [NumStages];
  stage_t               st_d [NumStages];
  logic [NumStages-1:0] vld_q, vld_d, ld;

  // Each stage loads when empty or when the stage after it moves on
  assign ld[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
  for (genvar i = 0; i < NumStages - 1; i++) begin : g_ld
    assign ld[i] = !vld_q[i] || ld[i+1];
  end
  assign in_ready_o = ld[0];

  assign vld_d[0] = ld[0] ? in_valid_i : vld_q[0];
  for (genvar i = 1; i < NumStages; i++) begin : g_vld
    assign vld_d[i] = ld[i] ? vld_q[i-1] : vld_q[i];
  end

  // Stage 0: capture
  always_comb begin
    st_d[0]     = '0;
    st_d[0].pix = in_pix_i;
  end

  // Stage 1: max/min, hue numerator and divisor
  logic [7:0]  p_r, p_g, p_b, p_mx, p_mn, p_d;
  logic [10:0] p_n;
  always_comb begin
    p_r = st_q[0].pix.red;
    p_g = st_q[0].pix.green;
    p_b = st_q[0].pix.blue;
    p_mx = p_r;
    p_mn = p_r;
    if (p_g > p_mx) p_mx = p_g;
    if (p_b > p_mx) p_mx = p_b;
    if (p_g < p_mn) p_mn = p_g;
    if (p_b < p_mn) p_mn = p_b;
    p_d = p_mx - p_mn;
    if (p_mx == p_r) begin
      // only this sector can go negative; fold it up by six sectors
      if (p_g >= p_b) p_n = 11'(p_g) - 11'(p_b);
      else            p_n = 11'(p_d) * 11'd6 - (11'(p_b) - 11'(p_g));
    end else if (p_mx == p_g) begin
      p_n = 11'(p_b) + {2'b00, p_d, 1'b0} - 11'(p_r);
    end else begin
      p_n = 11'(p_r) + {1'b0, p_d, 2'b00} - 11'(p_g);
    end
    st_d[1]     = st_q[0];
    st_d[1].quo = '0;
    if (p_d == 8'd0) begin
      st_d[1].rem = '0;
      st_d[1].den = DenW'(1);
    end else begin
      st_d[1].rem = RemW'(p_n) * RemW'(60) + RemW'(p_d);
      st_d[1].den = {p_d, 1'b0};
    end
  end

  // Stages 2..: one quotient bit each, MSB first
  for (genvar i = 2; i < NumStages; i++) begin : g_div
    localparam int unsigned K = NumStages - 1 - i;
    logic [RemW-1:0] den_sh;
    assign den_sh = RemW'(st_q[i-1].den) << K;
    always_comb begin
      st_d[i] = st_q[i-1];
      if (st_q[i-1].rem >= den_sh) begin
        st_d[i].rem    = st_q[i-1].rem - den_sh;
        st_d[i].quo[K] = 1'b1;
      end
    end
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (ld[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hue wrap and strict window compare
  logic [QuoW-1:0] hue;
  assign hue = (st_q[NumStages-1].quo >= HueWrap) ? st_q[NumStages-1].quo - HueWrap
                                                  : st_q[NumStages-1].quo;

  assign out_valid_o        = vld_q[NumStages-1];
  assign out_item_o.pix     = st_q[NumStages-1].pix;
  assign out_item_o.matched = (hue > cfg_i.hue_lower_bound) &&
                              (hue < cfg_i.hue_upper_bound);

endmodule

// ===== rtl/core/hkpt_fifo.sv =====
// Small register queue decoupling the classifier from the tint datapath.
// Depends on hkpt_pkg.
module hkpt_fifo #(
  parameter int unsigned Depth = hkpt_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hkpt_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hkpt_pkg::item_t out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hkpt_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/hkpt_back.sv =====
// Back end: gray level, blend toward white, per-channel tint scaling.
// Depends on hkpt_pkg; last stage is the output register.
module hkpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hkpt_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hkpt_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hkpt_pkg::item_t out_item_o
);

  localparam int unsigned NumStages = 4;
  localparam logic [8:0]  WtOne     = 9'd256;

  typedef struct packed {
    hkpt_pkg::item_t item;
    logic [15:0]     gray;     // 256 * gray
    logic [8:0]      wt;
    logic [23:0]     beta;     // 65536 * beta
    logic [15:0]     y_red;    // beta * tint / 65536
    logic [15:0]     y_green;
    logic [15:0]     y_blue;
  } stage_t;

  stage_t               st_q [NumStages];
  stage_t               st_d [NumStages];
  logic [NumStages-1:0] vld_q, vld_d, ld;

  // floor(y / 255) for y up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] t;
    t = 17'(y) + 17'(y[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  assign ld[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
  for (genvar i = 0; i < NumStages - 1; i++) begin : g_ld
    assign ld[i] = !vld_q[i] || ld[i+1];
  end
  assign in_ready_o = ld[0];

  assign vld_d[0] = ld[0] ? in_valid_i : vld_q[0];
  for (genvar i = 1; i < NumStages; i++) begin : g_vld
    assign vld_d[i] = ld[i] ? vld_q[i-1] : vld_q[i];
  end

  always_comb begin
    // gray numerator and saturated weight
    st_d[0]      = '0;
    st_d[0].item = in_item_i;
    st_d[0].gray = 16'(16'(in_item_i.pix.red)   * 16'd77  +
                       16'(in_item_i.pix.green) * 16'd151 +
                       16'(in_item_i.pix.blue)  * 16'd28);
    st_d[0].wt   = (cfg_i.blend_weight > WtOne) ? WtOne : cfg_i.blend_weight;

    // blend toward white: 255*256*(256-w) + w*gray
    st_d[1]      = st_q[0];
    st_d[1].beta = 24'(24'(WtOne - st_q[0].wt) * 24'd65280) +
                   24'(24'(st_q[0].wt) * 24'(st_q[0].gray));

    // tint products, keep the integer part above 2^16
    st_d[2]         = st_q[1];
    st_d[2].y_red   = 16'((32'(st_q[1].beta) * 32'(cfg_i.tint_red))   >> 16);
    st_d[2].y_green = 16'((32'(st_q[1].beta) * 32'(cfg_i.tint_green)) >> 16);
    st_d[2].y_blue  = 16'((32'(st_q[1].beta) * 32'(cfg_i.tint_blue))  >> 16);

    // divide by 255 and select tinted or original pixel
    st_d[3] = st_q[2];
    if (st_q[2].item.matched) begin
      st_d[3].item.pix.red   = div255(st_q[2].y_red);
      st_d[3].item.pix.green = div255(st_q[2].y_green);
      st_d[3].item.pix.blue  = div255(st_q[2].y_blue);
    end
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (ld[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign out_item_o  = st_q[NumStages-1].item;

endmodule

// ===== rtl/core/hue_keyed_pixel_tint.sv =====
// Top level of the hue keyed pixel tint block: config registers, front, queue, back.
// Depends on hkpt_pkg, hkpt_front, hkpt_fifo, hkpt_back.
//
//  channel   direction  tdata                               tuser
//  s_axis    in         [7:0] blue [15:8] green [23:16] red  -
//  m_axis    out        [7:0] blue [15:8] green [23:16] red  [0] hue_matched
//  cfg       in         cfg_index_i: register, cfg_data_i: value (ready always high)
//
// One pixel per clock sustained while m_axis is ready. Path from input transfer to
// result: 10 front stages (capture, hue prep, 8-step hue divider), the queue
// register, 4 back stages (gray, blend, tint multiply, /255 and output reg).
// Reset is asynchronous and clears pipeline valids and queue pointers; registers
// come up at their defaults. No clearing pass. A stalled m_axis backs up the back
// pipe first; the queue lets the front keep classifying until it fills.
module hue_keyed_pixel_tint #(
  parameter int unsigned FifoDepth = hkpt_pkg::FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // blue, green, red
  // pixel result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // blue, green, red
  output logic [0:0]                    m_axis_tuser,   // hue_matched
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hkpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hkpt_pkg::CfgDataW-1:0] cfg_data_i
);

  hkpt_pkg::cfg_t  cfg_q, cfg_d;
  hkpt_pkg::item_t front_item, back_in_item, back_out_item;
  logic            front_valid, front_ready;
  logic            back_in_valid, back_in_ready;

  // Registers always writable; user rule (not enforced): software only writes while idle
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        hkpt_pkg::REG_TINT_RED:  cfg_d.tint_red        = cfg_data_i[7:0];
        hkpt_pkg::REG_TINT_GRN:  cfg_d.tint_green      = cfg_data_i[7:0];
        hkpt_pkg::REG_TINT_BLU:  cfg_d.tint_blue       = cfg_data_i[7:0];
        hkpt_pkg::REG_BLEND_WT:  cfg_d.blend_weight    = cfg_data_i;
        hkpt_pkg::REG_HUE_LOWER: cfg_d.hue_lower_bound = cfg_data_i[7:0];
        hkpt_pkg::REG_HUE_UPPER: cfg_d.hue_upper_bound = cfg_data_i[7:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tint_red        <= hkpt_pkg::RST_TINT;
      cfg_q.tint_green      <= hkpt_pkg::RST_TINT;
      cfg_q.tint_blue       <= hkpt_pkg::RST_TINT;
      cfg_q.blend_weight    <= hkpt_pkg::RST_BLEND_WT;
      cfg_q.hue_lower_bound <= hkpt_pkg::RST_HUE_LOWER;
      cfg_q.hue_upper_bound <= hkpt_pkg::RST_HUE_UPPER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: hue and window match
  hkpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pix_i    (hkpt_pkg::pix_t'(s_axis_tdata)),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  // Queue between classifier and datapath
  hkpt_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (back_in_valid),
    .out_ready_i (back_in_ready),
    .out_item_o  (back_in_item)
  );

  // Back: gray blend and tint
  hkpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (back_in_valid),
    .in_ready_o  (back_in_ready),
    .in_item_i   (back_in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (back_out_item)
  );

  assign m_axis_tdata    = back_out_item.pix;
  assign m_axis_tuser[0] = back_out_item.matched;

endmodule

// ===== rtl/core/hkpt_checker.sv =====
// Port-level checker for hue_keyed_pixel_tint, bound to the top level.
// Depends only on the top level's port list; attached by the bind at the end.
module hkpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [23:0]                   m_axis_tdata,
  input logic [0:0]                    m_axis_tuser,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  logic [15:0] pending_q;
  logic        in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Pixels taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (pending_q != '0) || in_xfer)
    else $error("result without a pending pixel");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write stalled");

endmodule

bind hue_keyed_pixel_tint hkpt_checker u_hkpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);
